/* hdl/ffd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers for the fractional feedback delay.
package ffd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int ADDR_W     = 18;
    localparam int FRAC_W     = 8;
    localparam int DELAY_W    = ADDR_W + FRAC_W;
    localparam int FB_W       = 16;
    localparam int MIX_W      = 17;
    localparam int GAIN_FRAC  = 16;
    localparam int COEF_W     = MIX_W;
    localparam int OPND_W     = SAMPLE_W + 1;
    localparam int PROD_W     = COEF_W + 1 + OPND_W;
    localparam int SUM_W      = PROD_W - GAIN_FRAC + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DELAY_W;
    localparam int TDATA_W    = 2 * SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET    = 26'd1228800;
    localparam logic [FB_W-1:0]    FEEDBACK_RESET = 16'd45875;
    localparam logic [MIX_W-1:0]   MIX_RESET      = 17'd65536;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_WAIT,
        ST_DIFF,
        ST_MUL_INT,
        ST_INTERP,
        ST_DIFF_MIX,
        ST_MUL_MIX,
        ST_MIX,
        ST_MUL_FB,
        ST_FBK,
        ST_WRITE,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          waddr;
        logic signed [SAMPLE_W-1:0] wdata_l;
        logic signed [SAMPLE_W-1:0] wdata_r;
        logic [ADDR_W-1:0]          raddr;
    } store_req_t;

    // Clamp a widened sum back into the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] max_v;
        logic signed [SUM_W-1:0] min_v;
        max_v = SUM_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
        min_v = SUM_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
        if (v > max_v)
        begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (v < min_v)
        begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

/* hdl/ffd_store.sv */
`timescale 1ns / 1ps
// Left and right delay stores: one shared write port, one shared registered read port.
module ffd_store (
    input  logic                                clk,
    input  ffd_pkg::store_req_t                 req,
    output logic signed [ffd_pkg::SAMPLE_W-1:0] rdata_l,
    output logic signed [ffd_pkg::SAMPLE_W-1:0] rdata_r
);

    logic signed [ffd_pkg::SAMPLE_W-1:0] mem_l [2**ffd_pkg::ADDR_W];
    logic signed [ffd_pkg::SAMPLE_W-1:0] mem_r [2**ffd_pkg::ADDR_W];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_l[req.waddr] <= req.wdata_l;
            mem_r[req.waddr] <= req.wdata_r;
        end
        rdata_l <= mem_l[req.raddr];
        rdata_r <= mem_r[req.raddr];
    end

endmodule

/* hdl/fractional_feedback_delay.sv */
`timescale 1ns / 1ps
// Stereo feedback delay with fractional read point and linear interpolation.
//
// After reset the block sweeps both 262144-entry delay stores to zero, one
// entry per cycle, and s_tready stays low for the whole sweep; configuration
// writes are taken during that pass as at any other time. Each request then
// steps through RD1, RD2 and WAIT, which read the two neighboring store
// entries through the single read port; each channel then makes three passes
// (interpolate, wet mix, feedback) through one shared 18 x 25 multiplier, an
// operand, a multiply and a rounding/saturation step per pass with the
// feedback operand staged during the mix rounding step; then WRITE writes
// both stores, DONE loads the output register and IDLE waits for the next
// request. When the read index lands on the write index (only at a delay of
// zero) the inputs pass straight through, the stores are left alone, and the
// request goes from IDLE straight to DONE. The finished result sits in an
// output register, so a slow consumer stalls the block only when a second
// result is ready to leave. Config writes belong to idle periods only.
module fractional_feedback_delay (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ffd_pkg::TDATA_W-1:0]        s_tdata,   // left_in[23:0], right_in[47:24]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ffd_pkg::TDATA_W-1:0]        m_tdata,   // left_out[23:0], right_out[47:24]
    input  logic                               cfg_we,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SW = ffd_pkg::SAMPLE_W;
    localparam int AW = ffd_pkg::ADDR_W;
    localparam int FW = ffd_pkg::FRAC_W;
    localparam int PW = ffd_pkg::PROD_W;
    localparam int GF = ffd_pkg::GAIN_FRAC;

    // Configuration registers
    logic [ffd_pkg::DELAY_W-1:0] delay_reg;
    logic [ffd_pkg::FB_W-1:0]    feedback_reg;
    logic [ffd_pkg::MIX_W-1:0]   mix_reg;

    // Sequencer
    ffd_pkg::seq_state_t state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg;
    logic [AW-1:0]       wp_reg;
    logic                lane_reg;

    // Per-request working registers
    logic signed [SW-1:0]     in_l_reg, in_r_reg;
    logic [AW-1:0]            ri_reg;
    logic [FW-1:0]            frac_reg;
    logic                     active_reg;
    logic signed [SW-1:0]     d1_l_reg, d1_r_reg, d2_l_reg, d2_r_reg;
    logic signed [SW-1:0]     delayed_reg;
    logic signed [ffd_pkg::OPND_W-1:0] opnd_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [SW-1:0]     out_l_reg, out_r_reg, wr_l_reg, wr_r_reg;

    // Output register
    logic                     m_tvalid_reg;
    logic [ffd_pkg::TDATA_W-1:0] m_tdata_reg;

    // Store interface
    ffd_pkg::store_req_t      store_req;
    logic signed [SW-1:0]     rdata_l, rdata_r;

    // Datapath helpers
    logic [ffd_pkg::DELAY_W-1:0] read_point;
    logic                     s_accept;
    logic                     load_out;
    logic signed [SW-1:0]     dry, d1, d2;
    logic [ffd_pkg::COEF_W-1:0] coef;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     interp_acc;
    logic signed [PW-1:0]     gain_round;
    logic signed [ffd_pkg::SUM_W-1:0] gain_sum;
    logic signed [SW-1:0]     gain_sat;

    assign s_tready = (state_reg == ffd_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign load_out = (state_reg == ffd_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Read point: write position minus the delay, modulo the whole store.
    assign read_point = {wp_reg, {FW{1'b0}}} - delay_reg;

    assign dry = lane_reg ? in_r_reg : in_l_reg;
    assign d1  = lane_reg ? d1_r_reg : d1_l_reg;
    assign d2  = lane_reg ? d2_r_reg : d2_l_reg;

    // Shared multiplier: coefficient selected by the pass, operand staged earlier.
    always_comb
    begin
        case (state_reg)
            ffd_pkg::ST_MUL_INT: coef = ffd_pkg::COEF_W'(frac_reg);
            ffd_pkg::ST_MUL_MIX: coef = mix_reg;
            ffd_pkg::ST_MUL_FB:  coef = ffd_pkg::COEF_W'(feedback_reg);
            default:             coef = '0;
        endcase
    end

    assign prod_next = PW'(signed'({1'b0, coef})) * PW'(opnd_reg);

    // Interpolation: d1 * 2^F + frac * (d2 - d1) + half, floor-shifted by F.
    assign interp_acc = (PW'(d1) <<< FW) + prod_reg + PW'(signed'(1 << (FW - 1)));

    // Gain rounding shared by the mix and feedback passes.
    assign gain_round = (prod_reg + PW'(signed'(1 << (GF - 1)))) >>> GF;
    assign gain_sum   = ffd_pkg::SUM_W'(dry) + gain_round[ffd_pkg::SUM_W-1:0];
    assign gain_sat   = ffd_pkg::sat_sample(gain_sum);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffd_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    state_next = ffd_pkg::ST_IDLE;
                end
            end
            ffd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (read_point[ffd_pkg::DELAY_W-1:FW] != wp_reg) ?
                                 ffd_pkg::ST_RD1 : ffd_pkg::ST_DONE;
                end
            end
            ffd_pkg::ST_RD1:      state_next = ffd_pkg::ST_RD2;
            ffd_pkg::ST_RD2:      state_next = ffd_pkg::ST_WAIT;
            ffd_pkg::ST_WAIT:     state_next = ffd_pkg::ST_DIFF;
            ffd_pkg::ST_DIFF:     state_next = ffd_pkg::ST_MUL_INT;
            ffd_pkg::ST_MUL_INT:  state_next = ffd_pkg::ST_INTERP;
            ffd_pkg::ST_INTERP:   state_next = ffd_pkg::ST_DIFF_MIX;
            ffd_pkg::ST_DIFF_MIX: state_next = ffd_pkg::ST_MUL_MIX;
            ffd_pkg::ST_MUL_MIX:  state_next = ffd_pkg::ST_MIX;
            ffd_pkg::ST_MIX:      state_next = ffd_pkg::ST_MUL_FB;
            ffd_pkg::ST_MUL_FB:   state_next = ffd_pkg::ST_FBK;
            ffd_pkg::ST_FBK:
            begin
                state_next = lane_reg ? ffd_pkg::ST_WRITE : ffd_pkg::ST_DIFF;
            end
            ffd_pkg::ST_WRITE:    state_next = ffd_pkg::ST_DONE;
            ffd_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ffd_pkg::ST_IDLE;
                end
            end
            default:              state_next = ffd_pkg::ST_IDLE;
        endcase
    end

    // Store port drive
    always_comb
    begin
        store_req       = '0;
        store_req.raddr = ri_reg;
        case (state_reg)
            ffd_pkg::ST_CLEAR:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = clr_cnt_reg;
            end
            ffd_pkg::ST_RD2:
            begin
                store_req.raddr = ri_reg + AW'(1);
            end
            ffd_pkg::ST_WRITE:
            begin
                store_req.we      = 1'b1;
                store_req.waddr   = wp_reg;
                store_req.wdata_l = wr_l_reg;
                store_req.wdata_r = wr_r_reg;
            end
            default:
            begin
                store_req.we = 1'b0;
            end
        endcase
    end

    ffd_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rdata_l (rdata_l),
        .rdata_r (rdata_r)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffd_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            wp_reg       <= '0;
            lane_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            delay_reg    <= ffd_pkg::DELAY_RESET;
            feedback_reg <= ffd_pkg::FEEDBACK_RESET;
            mix_reg      <= ffd_pkg::MIX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ffd_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (s_accept)
            begin
                lane_reg <= 1'b0;
            end
            else if (state_reg == ffd_pkg::ST_FBK)
            begin
                lane_reg <= ~lane_reg;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
                wp_reg       <= wp_reg + AW'(1);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ffd_pkg::REG_DELAY:    delay_reg    <= cfg_wdata;
                    ffd_pkg::REG_FEEDBACK: feedback_reg <= cfg_wdata[ffd_pkg::FB_W-1:0];
                    ffd_pkg::REG_MIX:      mix_reg      <= cfg_wdata[ffd_pkg::MIX_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ffd_pkg::ST_IDLE:
            begin
                // Capture the request; outputs default to dry for pass-through.
                in_l_reg   <= s_tdata[SW-1:0];
                in_r_reg   <= s_tdata[2*SW-1:SW];
                out_l_reg  <= s_tdata[SW-1:0];
                out_r_reg  <= s_tdata[2*SW-1:SW];
                ri_reg     <= read_point[ffd_pkg::DELAY_W-1:FW];
                frac_reg   <= read_point[FW-1:0];
                active_reg <= (read_point[ffd_pkg::DELAY_W-1:FW] != wp_reg);
            end
            ffd_pkg::ST_RD2:
            begin
                d1_l_reg <= rdata_l;
                d1_r_reg <= rdata_r;
            end
            ffd_pkg::ST_WAIT:
            begin
                d2_l_reg <= rdata_l;
                d2_r_reg <= rdata_r;
            end
            ffd_pkg::ST_DIFF:
            begin
                opnd_reg <= ffd_pkg::OPND_W'(d2) - ffd_pkg::OPND_W'(d1);
            end
            ffd_pkg::ST_INTERP:
            begin
                delayed_reg <= SW'(interp_acc >>> FW);
            end
            ffd_pkg::ST_DIFF_MIX:
            begin
                opnd_reg <= ffd_pkg::OPND_W'(delayed_reg) - ffd_pkg::OPND_W'(dry);
            end
            ffd_pkg::ST_MIX:
            begin
                if (lane_reg)
                begin
                    out_r_reg <= gain_sat;
                end
                else
                begin
                    out_l_reg <= gain_sat;
                end
                opnd_reg <= ffd_pkg::OPND_W'(delayed_reg);
            end
            ffd_pkg::ST_FBK:
            begin
                if (lane_reg)
                begin
                    wr_r_reg <= gain_sat;
                end
                else
                begin
                    wr_l_reg <= gain_sat;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == ffd_pkg::ST_MUL_INT || state_reg == ffd_pkg::ST_MUL_MIX ||
            state_reg == ffd_pkg::ST_MUL_FB)
        begin
            prod_reg <= prod_next;
        end
        if (load_out)
        begin
            m_tdata_reg <= {out_r_reg, out_l_reg};
        end
    end

    // The store is written only by the clearing pass or at the write position.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.we |-> (state_reg == ffd_pkg::ST_CLEAR || state_reg == ffd_pkg::ST_WRITE))
        else $error("store written outside clear or write step");

    // A request that writes the store never has its read point on the write position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffd_pkg::ST_WRITE) |-> (active_reg && ri_reg != wp_reg))
        else $error("store write on a pass-through request");

    // Each result leaving the core advances the write position by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (wp_reg == $past(wp_reg) + AW'(1)) && m_tvalid_reg)
        else $error("write position did not advance with the result");

    // No request is taken while the stores are being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffd_pkg::ST_CLEAR) |-> !s_tready && !m_tvalid_reg)
        else $error("request accepted during clearing pass");

endmodule
